/* rtl/core/ssiu_pkg.sv */
`default_nettype none

package ssiu_pkg;

  localparam int VALUE_W        = 32;
  localparam int LIST_DEPTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_ISECT  = 2'd2,
    OP_UNION  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MRG_ISECT,
    ST_MRG_UNION
  } state_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [VALUE_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   result_value;
    logic                 empty_res;
    logic                 overflow;
    logic                 last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic adv_a;
    logic adv_b;
    logic emit;
    logic emit_b;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_more;
    logic b_more;
    logic a_lt_b;
    logic a_eq_b;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/ssiu_list.sv */
`default_nettype none

// Sorted list held as a row of cells: a push drops the value into its place.
module ssiu_list import ssiu_pkg::*; #(
  parameter  int DEPTH = LIST_DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int IW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               clear,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [CW-1:0]      rd_idx,
  output logic      [CW-1:0]      count,
  output logic                    full,
  output logic      [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] ent    [DEPTH];
  logic [VALUE_W-1:0] cell_d [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   we;

  assign full = (count == CW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign gt[i] = (count > CW'(i)) && (ent[i] > value);
    assign we[i] = push && !full && (gt[i] || (count == CW'(i)));
    if (i == 0) begin : g_head
      assign cell_d[i] = value;
    end else begin : g_body
      // take the neighbour below when the new value lands further down
      assign cell_d[i] = gt[i-1] ? ent[i-1] : value;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (we[i]) begin
        ent[i] <= cell_d[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (push && !full) begin
      count <= count + CW'(1);
    end
  end

  assign rd_data = ent[rd_idx[IW-1:0]];

endmodule

`default_nettype wire

/* rtl/core/ssiu_datapath.sv */
`default_nettype none

module ssiu_datapath import ssiu_pkg::*; #(
  parameter  int DEPTH = LIST_DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cmd_t  cmd,
  output stat_t      stat,
  output result_t    result,
  output logic       result_valid
);

  logic [CW-1:0]      ia;
  logic [CW-1:0]      ib;
  logic [CW-1:0]      cnt_a;
  logic [CW-1:0]      cnt_b;
  logic               full_a;
  logic               full_b;
  logic [VALUE_W-1:0] a_rd;
  logic [VALUE_W-1:0] b_rd;
  logic [VALUE_W-1:0] emit_val;
  logic [VALUE_W-1:0] pend_value;
  logic               pend_valid;
  logic               ovf;

  ssiu_list #(.DEPTH(DEPTH)) u_list_a (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.push_a),
    .clear   (cmd.finish),
    .value   (item.value),
    .rd_idx  (ia),
    .count   (cnt_a),
    .full    (full_a),
    .rd_data (a_rd)
  );

  ssiu_list #(.DEPTH(DEPTH)) u_list_b (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.push_b),
    .clear   (cmd.finish),
    .value   (item.value),
    .rd_idx  (ib),
    .count   (cnt_b),
    .full    (full_b),
    .rd_data (b_rd)
  );

  assign stat.a_more = (ia < cnt_a);
  assign stat.b_more = (ib < cnt_b);
  assign stat.a_lt_b = (a_rd < b_rd);
  assign stat.a_eq_b = (a_rd == b_rd);

  assign emit_val = cmd.emit_b ? b_rd : a_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ia           <= '0;
      ib           <= '0;
      ovf          <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // strobe on every emit once a value is held back, and on the finish
      result_valid <= cmd.finish || (cmd.emit && pend_valid);
      if ((cmd.push_a && full_a) || (cmd.push_b && full_b)) begin
        ovf <= 1'b1;
      end
      if (cmd.adv_a) begin
        ia <= ia + CW'(1);
      end
      if (cmd.adv_b) begin
        ib <= ib + CW'(1);
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        ia         <= '0;
        ib         <= '0;
        ovf        <= 1'b0;
        pend_valid <= 1'b0;
      end
    end
  end

  // hold one value back so the final one can carry the last mark
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_value <= emit_val;
      result     <= '{result_value: pend_value, empty_res: 1'b0, overflow: ovf, last: 1'b0};
    end
    if (cmd.finish) begin
      if (pend_valid) begin
        result <= '{result_value: pend_value, empty_res: 1'b0, overflow: ovf, last: 1'b1};
      end else begin
        result <= '{result_value: '0, empty_res: 1'b1, overflow: ovf, last: 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ssiu_ctrl.sv */
`default_nettype none

module ssiu_ctrl import ssiu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;
  logic   isect_done;
  logic   union_done;

  assign isect_done = !(stat.a_more && stat.b_more);
  assign union_done = !(stat.a_more || stat.b_more);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (item.opcode == OP_ISECT)) begin
          state_next = ST_MRG_ISECT;
        end else if (start && (item.opcode == OP_UNION)) begin
          state_next = ST_MRG_UNION;
        end
      end
      ST_MRG_ISECT: begin
        if (isect_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MRG_UNION: begin
        if (union_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.push_a = start && (item.opcode == OP_PUSH_A);
        cmd.push_b = start && (item.opcode == OP_PUSH_B);
      end
      ST_MRG_ISECT: begin
        if (isect_done) begin
          cmd.finish = 1'b1;
        end else if (stat.a_eq_b) begin
          cmd.adv_a = 1'b1;
          cmd.adv_b = 1'b1;
          cmd.emit  = 1'b1;
        end else if (stat.a_lt_b) begin
          cmd.adv_a = 1'b1;
        end else begin
          cmd.adv_b = 1'b1;
        end
      end
      ST_MRG_UNION: begin
        if (union_done) begin
          cmd.finish = 1'b1;
        end else if (stat.a_more && stat.b_more) begin
          cmd.emit = 1'b1;
          if (stat.a_eq_b) begin
            cmd.adv_a = 1'b1;
            cmd.adv_b = 1'b1;
          end else if (stat.a_lt_b) begin
            cmd.adv_a = 1'b1;
          end else begin
            cmd.adv_b  = 1'b1;
            cmd.emit_b = 1'b1;
          end
        end else if (stat.a_more) begin
          cmd.adv_a = 1'b1;
          cmd.emit  = 1'b1;
        end else begin
          cmd.adv_b  = 1'b1;
          cmd.emit   = 1'b1;
          cmd.emit_b = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/sorted_set_intersect_union.sv */
// Two lists of 32-bit offsets, A and B, are loaded one value per transfer; each list keeps
// its values in ascending order as they arrive, so busy stays low through a push.
// A finish transfer starts the merge: the comparators between the two list heads take
// one step per cycle, and busy stays high until the merge has used up the heads it needs.
// Results leave through an output register, one per strobe, in
// ascending order; the final one carries last and appears in the same cycle that busy falls.
// The receiver cannot stall: result_valid is high for exactly one cycle per result and the
// value must be taken then. An empty answer gives one result with empty_res and last set.
// Pushes to a full list are dropped and reported through overflow on every result of the
// next finish; the finish then clears both lists and the overflow flag.
`default_nettype none

module sorted_set_intersect_union import ssiu_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output result_t    result,
  output logic       result_valid
);

  cmd_t  cmd;
  stat_t stat;

  // decode pushes and sequence the merge: choose which head to advance and whether to emit it
  ssiu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold the lists, the merge pointers and the output register
  ssiu_datapath #(.DEPTH(LIST_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

/* rtl/core/ssiu_checker.sv */
`default_nettype none

module ssiu_checker import ssiu_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire item_t   item,
  input wire logic    busy,
  input wire result_t result,
  input wire logic    result_valid
);

  logic push_acc;
  logic fin_acc;

  assign push_acc = start && !busy
                    && ((item.opcode == OP_PUSH_A) || (item.opcode == OP_PUSH_B));
  assign fin_acc  = start && !busy
                    && ((item.opcode == OP_ISECT) || (item.opcode == OP_UNION));

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.empty_res |-> result.last && (result.result_value == '0))
    else $error("empty answer without last mark or with a value");

  a_push_no_busy: assert property (@(posedge clk) disable iff (rst)
    push_acc |=> !busy && !result_valid)
    else $error("push made the block busy or produced a result");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    fin_acc |=> busy)
    else $error("finish did not start the merge");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("last result while still merging");

endmodule

bind sorted_set_intersect_union ssiu_checker u_ssiu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .item         (item),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);

`default_nettype wire

/* dv/tb_sorted_set_intersect_union.sv */
`timescale 1ns / 100ps

module tb_sorted_set_intersect_union;
  import ssiu_pkg::*;

  localparam int DEPTH        = LIST_DEPTH_DEF;
  // Quiet cycles tolerated: well beyond a full merge and a sender gap.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to watch for stray results once every expectation has been met.
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEM_TARGET  = 330;

  typedef logic [VALUE_W-1:0] offset_q_t[$];

  // Keeps its own copy of both lists and the overflow flag, works out the merged answer
  // on every finish and holds it until the block delivers it.
  class set_merge_board;
    offset_q_t list_a;
    offset_q_t list_b;
    bit        ovf_seen;
    result_t   merged_due[$];
    int        n_bad;
    int        n_checked;
    int        n_finish;
    int        n_ovf_results;

    function offset_q_t ascending(offset_q_t v);
      offset_q_t          s;
      logic [VALUE_W-1:0] key;
      int                 j;
      s = v;
      for (int i = 1; i < s.size(); i++) begin
        key = s[i];
        j   = i;
        while (j > 0 && s[j-1] > key) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = key;
      end
      return s;
    endfunction

    function void queue_offset(logic [VALUE_W-1:0] v, bit is_empty);
      result_t r;
      r.result_value = v;
      r.empty_res    = is_empty;
      r.overflow     = ovf_seen;
      r.last         = is_empty;
      merged_due     = {merged_due, r};
    endfunction

    function void note_transfer(item_t it);
      offset_q_t a;
      offset_q_t b;
      int        ia;
      int        ib;
      int        first;
      case (it.opcode)
        OP_PUSH_A: begin
          if (list_a.size() < DEPTH) list_a = {list_a, it.value};
          else ovf_seen = 1'b1;
        end
        OP_PUSH_B: begin
          if (list_b.size() < DEPTH) list_b = {list_b, it.value};
          else ovf_seen = 1'b1;
        end
        default: begin
          a     = ascending(list_a);
          b     = ascending(list_b);
          ia    = 0;
          ib    = 0;
          first = merged_due.size();
          while (ia < a.size() && ib < b.size()) begin
            if (a[ia] < b[ib]) begin
              if (it.opcode == OP_UNION) queue_offset(a[ia], 1'b0);
              ia++;
            end else if (a[ia] > b[ib]) begin
              if (it.opcode == OP_UNION) queue_offset(b[ib], 1'b0);
              ib++;
            end else begin
              queue_offset(a[ia], 1'b0);
              ia++;
              ib++;
            end
          end
          if (it.opcode == OP_UNION) begin
            while (ia < a.size()) begin
              queue_offset(a[ia], 1'b0);
              ia++;
            end
            while (ib < b.size()) begin
              queue_offset(b[ib], 1'b0);
              ib++;
            end
          end
          if (merged_due.size() == first) begin
            queue_offset('0, 1'b1);
          end else begin
            merged_due[merged_due.size() - 1].last = 1'b1;
          end
          list_a.delete();
          list_b.delete();
          ovf_seen = 1'b0;
          n_finish++;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (merged_due.size() == 0) begin
        $error("result with nothing expected: result_value %h", got.result_value);
        n_bad++;
        return;
      end
      want = merged_due.pop_front();
      n_checked++;
      if (want.overflow) n_ovf_results++;
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %h, got %h", want.result_value, got.result_value);
        n_bad++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %b, got %b", want.empty_res, got.empty_res);
        n_bad++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
        n_bad++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        n_bad++;
      end
    endfunction
  endclass

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  result_t result;
  logic    result_valid;

  set_merge_board board;
  int             n_sent;
  int             stall_cycles;
  bit             idle_on;

  sorted_set_intersect_union u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  always #1 clk = ~clk;

  // Take every strobed result; the receiver has no way to hold the block off.
  always @(posedge clk) begin
    if (!rst && result_valid) board.check_result(result);
  end

  // Count cycles with neither an input transfer nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with %0d results outstanding", stall_cycles,
             board.merged_due.size());
    $display("tb_sorted_set_intersect_union: FAIL");
    $finish;
  end

  // Present one item and hold it until the block takes it. Idle cycles come first, with
  // start low and junk on the item bus, so gaps also land while a merge is running.
  task automatic send_item(input opcode_t op, input logic [VALUE_W-1:0] v);
    item_t it;
    it.opcode = op;
    it.value  = v;
    while (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      item  <= '{opcode: opcode_t'($urandom_range(3)), value: $urandom};
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    // busy read straight after the edge is the value the block saw at that edge
    do @(posedge clk); while (busy);
    board.note_transfer(it);
    n_sent++;
    // put a long stretch with no idle gaps into the middle of the run
    idle_on = !(n_sent >= 120 && n_sent < 200);
  endtask

  // Draw an offset: mostly clustered round a base so that matches are common, else anywhere.
  function automatic logic [VALUE_W-1:0] pick_offset(logic [VALUE_W-1:0] base, bit spread);
    if (spread) return $urandom;
    return base + $urandom_range(12);
  endfunction

  // Load both lists with interleaved pushes, then finish.
  task automatic run_set(input int na, input int nb, input opcode_t fin, input bit spread);
    logic [VALUE_W-1:0] base;
    int                 left_a;
    int                 left_b;
    base   = $urandom;
    left_a = na;
    left_b = nb;
    while (left_a + left_b > 0) begin
      if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 0)) begin
        send_item(OP_PUSH_A, pick_offset(base, spread));
        left_a--;
      end else begin
        send_item(OP_PUSH_B, pick_offset(base, spread));
        left_b--;
      end
    end
    send_item(fin, $urandom);
  endtask

  initial begin
    int      set_no;
    int      mode;
    opcode_t fin;
    board   = new();
    n_sent  = 0;
    idle_on = 1'b1;
    set_no  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Finish on two empty lists, both ways: expect the empty answer.
    send_item(OP_ISECT, 32'hFFFF_FFFF);
    send_item(OP_UNION, 32'h0000_0000);
    // Extreme offsets, pushed out of order.
    send_item(OP_PUSH_A, 32'h0000_0000);
    send_item(OP_PUSH_A, 32'hFFFF_FFFF);
    send_item(OP_PUSH_B, 32'hFFFF_FFFF);
    send_item(OP_PUSH_B, 32'h0000_0000);
    send_item(OP_PUSH_B, 32'h0000_0005);
    send_item(OP_ISECT, 32'h0);
    // Duplicates inside one list survive the union, one matched pair collapses.
    send_item(OP_PUSH_A, 32'd7);
    send_item(OP_PUSH_A, 32'd7);
    send_item(OP_PUSH_B, 32'd7);
    send_item(OP_PUSH_A, 32'd3);
    send_item(OP_UNION, 32'hA5A5_A5A5);
    // Disjoint lists: empty intersection.
    send_item(OP_PUSH_A, 32'd1);
    send_item(OP_PUSH_B, 32'd2);
    send_item(OP_ISECT, 32'h5A5A_5A5A);
    // Only one list loaded, each way.
    send_item(OP_PUSH_B, 32'h8000_0000);
    send_item(OP_PUSH_B, 32'h7FFF_FFFF);
    send_item(OP_UNION, 32'h0);
    send_item(OP_PUSH_A, 32'h8000_0000);
    send_item(OP_ISECT, 32'h0);

    // Random sets: mostly small lists, now and then full ones with pushes dropped.
    while (n_sent < ITEM_TARGET) begin
      mode = $urandom_range(99);
      fin  = $urandom_range(1) ? OP_UNION : OP_ISECT;
      if (set_no == 0) begin
        run_set(DEPTH + 2, DEPTH + 1, OP_UNION, 1'b1);
      end else if (set_no == 1) begin
        run_set(DEPTH, DEPTH, OP_ISECT, 1'b0);
      end else if (mode < 5) begin
        run_set($urandom_range(DEPTH, DEPTH + 3), $urandom_range(8), fin,
                $urandom_range(1));
      end else if (mode < 9) begin
        run_set($urandom_range(8), $urandom_range(DEPTH, DEPTH + 3), fin,
                $urandom_range(1));
      end else if (mode < 19) begin
        // noise: an item with any opcode and value, finishes on odd contents included
        send_item(opcode_t'($urandom_range(3)), $urandom);
      end else begin
        run_set($urandom_range(8), $urandom_range(8), fin, $urandom_range(3) == 0);
      end
      set_no++;
    end
    // Close off whatever the noise left loaded.
    send_item(OP_UNION, $urandom);
    start <= 1'b0;

    while (board.merged_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d transfers over %0d finishes; checked %0d results", n_sent,
             board.n_finish, board.n_checked);
    $display("%0d of those results carried the overflow flag", board.n_ovf_results);
    if (board.n_bad == 0 && board.merged_due.size() == 0) begin
      $display("tb_sorted_set_intersect_union: PASS");
    end else begin
      $display("tb_sorted_set_intersect_union: FAIL");
    end
    $finish;
  end

endmodule
